// ===== sv/ctt_pkg.sv =====
`timescale 1ns / 1ps
package ctt_pkg;

    localparam int BUCKETS_DEF = 1024;
    localparam int WAYS_DEF    = 4;
    localparam logic [15:0] TTL_RESET = 16'd60;

    localparam logic [31:0] PR1 = 32'h9E3779B1;
    localparam logic [31:0] PR2 = 32'h85EBCA77;
    localparam logic [31:0] PR3 = 32'hC2B2AE3D;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_CREATE = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_CREATED = 3'd1;
    localparam logic [2:0] ST_MISS    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_TICK    = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] addr_first;
        logic [31:0] addr_second;
        logic [15:0] port_first;
        logic [15:0] port_second;
        logic [7:0]  protocol;
        logic [15:0] client_id;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] owner_client;
        logic [9:0]  bucket_index;
        logic [1:0]  way_index;
    } rsp_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] addr_low;
        logic [31:0] addr_high;
        logic [31:0] ports;
        logic [7:0]  proto;
        logic [15:0] client;
        logic [31:0] expiry;
    } entry_t;

    typedef struct packed {
        logic       clr;
        logic       load;
        logic       tick;
        logic       emit_simple;
        logic [5:0] hstep;
        logic       rd;
        logic       upd;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic clr_last;
    } sts_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

endpackage

// ===== sv/ctt_in_if.sv =====
`timescale 1ns / 1ps
interface ctt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] addr_first;
    logic [31:0] addr_second;
    logic [15:0] port_first;
    logic [15:0] port_second;
    logic [7:0]  protocol;
    logic [15:0] client_id;

    modport source (output valid, func, addr_first, addr_second, port_first, port_second,
                    protocol, client_id, input ready);
    modport sink (input valid, func, addr_first, addr_second, port_first, port_second,
                  protocol, client_id, output ready);
endinterface

// ===== sv/ctt_out_if.sv =====
`timescale 1ns / 1ps
interface ctt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] owner_client;
    logic [9:0]  bucket_index;
    logic [1:0]  way_index;

    modport source (output valid, status, owner_client, bucket_index, way_index,
                    input ready);
    modport sink (input valid, status, owner_client, bucket_index, way_index,
                  output ready);
endinterface

// ===== sv/connection_tracking_table_core.sv =====
`timescale 1ns / 1ps
// channel   role    fields
// in_ch     sink    func, addr_first, addr_second, port_first, port_second,
//                   protocol, client_id
// out_ch    source  status, owner_client, bucket_index, way_index
// cfg       write   cfg_we, cfg_wdata (session_ttl)
//
// A lookup or create runs from transfer to result through six hash
// stages, one bucket read and one compare/write-back of the bucket row.
// A tick or an unused func code gives its result the cycle after transfer.
// After reset a clearing pass zeroes every bucket before in_ch is ready.
// The result waits in an output register; a stalled out_ch holds the block.
module connection_tracking_table_core
#(
    parameter int BUCKETS = ctt_pkg::BUCKETS_DEF,
    parameter int WAYS    = ctt_pkg::WAYS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    ctt_in_if.sink      in_ch,
    ctt_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    ctt_pkg::cmd_t cmd;
    ctt_pkg::sts_t sts;
    ctt_pkg::req_t req;
    ctt_pkg::rsp_t rsp;

    assign req.func        = in_ch.func;
    assign req.addr_first  = in_ch.addr_first;
    assign req.addr_second = in_ch.addr_second;
    assign req.port_first  = in_ch.port_first;
    assign req.port_second = in_ch.port_second;
    assign req.protocol    = in_ch.protocol;
    assign req.client_id   = in_ch.client_id;

    assign out_ch.status       = rsp.status;
    assign out_ch.owner_client = rsp.owner_client;
    assign out_ch.bucket_index = rsp.bucket_index;
    assign out_ch.way_index    = rsp.way_index;

    ctt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_func  (in_ch.func),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ctt_datapath #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .rsp       (rsp)
    );

endmodule

// ===== sv/ctt_ctrl.sv =====
`timescale 1ns / 1ps
module ctt_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    in_func,
    output logic          in_ready,
    input  ctt_pkg::sts_t sts,
    output ctt_pkg::cmd_t cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_H1    = 4'd2;
    localparam logic [3:0] S_H2    = 4'd3;
    localparam logic [3:0] S_H3    = 4'd4;
    localparam logic [3:0] S_H4    = 4'd5;
    localparam logic [3:0] S_H5    = 4'd6;
    localparam logic [3:0] S_H6    = 4'd7;
    localparam logic [3:0] S_RD    = 4'd8;
    localparam logic [3:0] S_CMP   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       acc;

    assign in_ready = (state_reg == S_IDLE) && sts.out_free;
    assign acc      = in_ready && in_valid;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    cmd.load = 1'b1;
                    if (in_func == ctt_pkg::FUNC_LOOKUP || in_func == ctt_pkg::FUNC_CREATE)
                    begin
                        state_next = S_H1;
                    end
                    else
                    begin
                        cmd.emit_simple = 1'b1;
                        cmd.tick        = (in_func == ctt_pkg::FUNC_TICK);
                    end
                end
            end
            S_H1:
            begin
                cmd.hstep[0] = 1'b1;
                state_next   = S_H2;
            end
            S_H2:
            begin
                cmd.hstep[1] = 1'b1;
                state_next   = S_H3;
            end
            S_H3:
            begin
                cmd.hstep[2] = 1'b1;
                state_next   = S_H4;
            end
            S_H4:
            begin
                cmd.hstep[3] = 1'b1;
                state_next   = S_H5;
            end
            S_H5:
            begin
                cmd.hstep[4] = 1'b1;
                state_next   = S_H6;
            end
            S_H6:
            begin
                cmd.hstep[5] = 1'b1;
                state_next   = S_RD;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (sts.out_free)
                begin
                    cmd.upd    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/ctt_datapath.sv =====
`timescale 1ns / 1ps
module ctt_datapath
#(
    parameter int BUCKETS = ctt_pkg::BUCKETS_DEF,
    parameter int WAYS    = ctt_pkg::WAYS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  ctt_pkg::cmd_t cmd,
    output ctt_pkg::sts_t sts,
    input  ctt_pkg::req_t req,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,
    input  logic          out_ready,
    output logic          out_valid,
    output ctt_pkg::rsp_t rsp
);

    localparam int BW = $clog2(BUCKETS);
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [31:0] ACC_INIT [4] = '{
        ctt_pkg::PR1 + ctt_pkg::PR2, ctt_pkg::PR2, 32'd0, 32'd0 - ctt_pkg::PR1};
    localparam int ROT [4] = '{1, 7, 12, 18};

    ctt_pkg::entry_t [WAYS-1:0] mem [BUCKETS];

    logic [15:0]   ttl_reg;
    logic [31:0]   now_reg;
    logic [1:0]    func_reg;
    logic [15:0]   client_reg;
    logic [31:0]   w_reg [4];
    logic [31:0]   m_reg [4];
    logic [31:0]   v_reg [4];
    logic [31:0]   h_reg;
    logic [BW-1:0] bucket_reg;
    logic [BW-1:0] clr_cnt_reg;
    logic          out_valid_reg;
    ctt_pkg::rsp_t rsp_reg;
    ctt_pkg::entry_t [WAYS-1:0] row_reg;

    logic [31:0] alo, ahi, ports;
    logic [31:0] hsum, hx;
    logic [63:0] bprod;
    logic [WAYS-1:0] live, match;
    logic          hit, have_free, wr_en;
    logic [WW-1:0] hit_way, free_way;
    logic [31:0]   exp_new;
    logic [31:0]   d;
    ctt_pkg::entry_t [WAYS-1:0] new_row;
    ctt_pkg::rsp_t rsp_next;

    assign alo   = (req.addr_first < req.addr_second) ? req.addr_first : req.addr_second;
    assign ahi   = (req.addr_first < req.addr_second) ? req.addr_second : req.addr_first;
    assign ports = (req.port_first < req.port_second) ? {req.port_second, req.port_first}
                                                      : {req.port_first, req.port_second};

    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.clr_last = (clr_cnt_reg == BW'(BUCKETS - 1));
    assign out_valid    = out_valid_reg;
    assign rsp          = rsp_reg;
    assign exp_new      = now_reg + 32'(ttl_reg);

    always_comb
    begin
        hsum = 32'd16;
        for (int i = 0; i < 4; i++)
        begin
            hsum = hsum + ctt_pkg::rotl(v_reg[i], ROT[i]);
        end
        hx    = h_reg ^ (h_reg >> 16);
        bprod = 64'(hx) * 64'(BUCKETS);
    end

    always_comb
    begin
        hit       = 1'b0;
        have_free = 1'b0;
        hit_way   = '0;
        free_way  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            d        = row_reg[w].expiry - now_reg;
            live[w]  = row_reg[w].valid && (d != 32'd0) && !d[31];
            match[w] = live[w] && (row_reg[w].addr_low == w_reg[0])
                       && (row_reg[w].addr_high == w_reg[1])
                       && (row_reg[w].ports == w_reg[2])
                       && (row_reg[w].proto == w_reg[3][7:0]);
            if (match[w] && !hit)
            begin
                hit     = 1'b1;
                hit_way = WW'(w);
            end
            if (!live[w] && !have_free)
            begin
                have_free = 1'b1;
                free_way  = WW'(w);
            end
        end
        new_row  = row_reg;
        rsp_next = '0;
        rsp_next.bucket_index = 10'(bucket_reg);
        wr_en    = 1'b0;
        if (hit)
        begin
            new_row[hit_way].expiry = exp_new;
            wr_en                   = 1'b1;
            rsp_next.status         = ctt_pkg::ST_HIT;
            rsp_next.owner_client   = row_reg[hit_way].client;
            rsp_next.way_index      = 2'(hit_way);
        end
        else if (func_reg == ctt_pkg::FUNC_LOOKUP)
        begin
            rsp_next.status = ctt_pkg::ST_MISS;
        end
        else if (!have_free)
        begin
            rsp_next.status = ctt_pkg::ST_FULL;
        end
        else
        begin
            new_row[free_way].valid     = 1'b1;
            new_row[free_way].addr_low  = w_reg[0];
            new_row[free_way].addr_high = w_reg[1];
            new_row[free_way].ports     = w_reg[2];
            new_row[free_way].proto     = w_reg[3][7:0];
            new_row[free_way].client    = client_reg;
            new_row[free_way].expiry    = exp_new;
            wr_en                       = 1'b1;
            rsp_next.status             = ctt_pkg::ST_CREATED;
            rsp_next.owner_client       = client_reg;
            rsp_next.way_index          = 2'(free_way);
        end
        if (cmd.emit_simple)
        begin
            rsp_next = '0;
            rsp_next.status = (req.func == ctt_pkg::FUNC_TICK) ? ctt_pkg::ST_TICK
                                                               : ctt_pkg::ST_MISS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg       <= ctt_pkg::TTL_RESET;
            now_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ttl_reg <= cfg_wdata;
            end
            if (cmd.tick)
            begin
                now_reg <= now_reg + 32'd1;
            end
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + BW'(1);
            end
            if (cmd.emit_simple || cmd.upd)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= req.func;
            client_reg <= req.client_id;
            w_reg[0]   <= alo;
            w_reg[1]   <= ahi;
            w_reg[2]   <= ports;
            w_reg[3]   <= {24'd0, req.protocol};
        end
        for (int i = 0; i < 4; i++)
        begin
            if (cmd.hstep[0])
            begin
                m_reg[i] <= w_reg[i] * ctt_pkg::PR2;
            end
            if (cmd.hstep[1])
            begin
                v_reg[i] <= ctt_pkg::rotl(ACC_INIT[i] + m_reg[i], 13) * ctt_pkg::PR1;
            end
        end
        if (cmd.hstep[2])
        begin
            h_reg <= hsum;
        end
        if (cmd.hstep[3])
        begin
            h_reg <= (h_reg ^ (h_reg >> 15)) * ctt_pkg::PR2;
        end
        if (cmd.hstep[4])
        begin
            h_reg <= (h_reg ^ (h_reg >> 13)) * ctt_pkg::PR3;
        end
        if (cmd.hstep[5])
        begin
            bucket_reg <= bprod[32 +: BW];
        end
        if (cmd.emit_simple || cmd.upd)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.upd && wr_en)
        begin
            mem[bucket_reg] <= new_row;
        end
        if (cmd.rd)
        begin
            row_reg <= mem[bucket_reg];
        end
    end

endmodule

// ===== tb/connection_tracking_table_core_test.sv =====
`timescale 1ns / 1ps
module connection_tracking_table_core_test;

    localparam int NBUCKETS  = 1024;
    localparam int NWAYS     = 4;
    localparam int NENTRIES  = NBUCKETS * NWAYS;
    localparam int WDOG_MAX  = 8000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    ctt_in_if  in_ch ();
    ctt_out_if out_ch ();

    connection_tracking_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [15:0] ttl_now;
    logic [31:0] seconds_now;
    logic        tab_valid  [NENTRIES];
    logic [31:0] tab_alo    [NENTRIES];
    logic [31:0] tab_ahi    [NENTRIES];
    logic [31:0] tab_ports  [NENTRIES];
    logic [7:0]  tab_proto  [NENTRIES];
    logic [15:0] tab_client [NENTRIES];
    logic [31:0] tab_expiry [NENTRIES];

    ctt_pkg::rsp_t pending_rsp [$];
    int   mismatches;
    bit   tx_idle;
    bit   rx_idle;
    int   hold_left;
    int   wdog;
    ctt_pkg::req_t flow_pool [0:15];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] xx_round(input logic [31:0] acc, input logic [31:0] w);
        logic [31:0] a;
        a = acc + w * ctt_pkg::PR2;
        a = rot_left(a, 13);
        return a * ctt_pkg::PR1;
    endfunction

    function automatic logic [31:0] tuple_hash(input logic [31:0] w0, input logic [31:0] w1,
                                               input logic [31:0] w2, input logic [31:0] w3);
        logic [31:0] h;
        h = rot_left(xx_round(ctt_pkg::PR1 + ctt_pkg::PR2, w0), 1)
          + rot_left(xx_round(ctt_pkg::PR2, w1), 7)
          + rot_left(xx_round(32'd0, w2), 12)
          + rot_left(xx_round(32'd0 - ctt_pkg::PR1, w3), 18);
        h = h + 32'd16;
        h = h ^ (h >> 15);
        h = h * ctt_pkg::PR2;
        h = h ^ (h >> 13);
        h = h * ctt_pkg::PR3;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic logic [31:0] key_ports(input ctt_pkg::req_t r);
        if (r.port_first < r.port_second)
            return {r.port_second, r.port_first};
        return {r.port_first, r.port_second};
    endfunction

    function automatic logic [9:0] bucket_of(input ctt_pkg::req_t r);
        logic [31:0] alo;
        logic [31:0] ahi;
        logic [31:0] h;
        alo = (r.addr_first < r.addr_second) ? r.addr_first : r.addr_second;
        ahi = (r.addr_first < r.addr_second) ? r.addr_second : r.addr_first;
        h = tuple_hash(alo, ahi, key_ports(r), {24'd0, r.protocol});
        return h[31:22];
    endfunction

    function automatic ctt_pkg::req_t random_tuple(input logic [1:0] f);
        ctt_pkg::req_t r;
        r.func        = f;
        r.addr_first  = $urandom;
        r.addr_second = $urandom;
        r.port_first  = $urandom;
        r.port_second = $urandom;
        r.protocol    = $urandom;
        r.client_id   = $urandom;
        return r;
    endfunction

    function automatic ctt_pkg::req_t tuple_in_bucket(input logic [9:0] b);
        ctt_pkg::req_t r;
        r = random_tuple(ctt_pkg::FUNC_CREATE);
        while (bucket_of(r) != b)
            r = random_tuple(ctt_pkg::FUNC_CREATE);
        return r;
    endfunction

    function automatic bit entry_live(input int i);
        logic [31:0] d;
        if (!tab_valid[i])
            return 1'b0;
        d = tab_expiry[i] - seconds_now;
        return (d != 32'd0) && !d[31];
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic predict_result(input ctt_pkg::req_t r);
        ctt_pkg::rsp_t e;
        logic [31:0] alo;
        logic [31:0] ahi;
        logic [31:0] pk;
        int          base;
        int          free_way;
        int          i;
        bit          done;
        e = '0;
        done = 1'b0;
        free_way = -1;
        if (r.func == ctt_pkg::FUNC_TICK)
        begin
            seconds_now = seconds_now + 32'd1;
            e.status = ctt_pkg::ST_TICK;
        end
        else if (r.func == FUNC_UNUSED)
            e.status = ctt_pkg::ST_MISS;
        else
        begin
            alo = (r.addr_first < r.addr_second) ? r.addr_first : r.addr_second;
            ahi = (r.addr_first < r.addr_second) ? r.addr_second : r.addr_first;
            pk  = key_ports(r);
            e.bucket_index = bucket_of(r);
            base = int'(e.bucket_index) * NWAYS;
            for (int w = 0; w < NWAYS; w++)
            begin
                i = base + w;
                if (done)
                    continue;
                if (entry_live(i))
                begin
                    if (tab_alo[i] == alo && tab_ahi[i] == ahi && tab_ports[i] == pk
                        && tab_proto[i] == r.protocol)
                    begin
                        tab_expiry[i] = seconds_now + 32'(ttl_now);
                        e.status = ctt_pkg::ST_HIT;
                        e.owner_client = tab_client[i];
                        e.way_index = 2'(w);
                        done = 1'b1;
                    end
                end
                else if (free_way < 0)
                    free_way = w;
            end
            if (!done)
            begin
                if (r.func == ctt_pkg::FUNC_LOOKUP)
                    e.status = ctt_pkg::ST_MISS;
                else if (free_way < 0)
                    e.status = ctt_pkg::ST_FULL;
                else
                begin
                    i = base + free_way;
                    tab_valid[i]  = 1'b1;
                    tab_alo[i]    = alo;
                    tab_ahi[i]    = ahi;
                    tab_ports[i]  = pk;
                    tab_proto[i]  = r.protocol;
                    tab_client[i] = r.client_id;
                    tab_expiry[i] = seconds_now + 32'(ttl_now);
                    e.status = ctt_pkg::ST_CREATED;
                    e.owner_client = r.client_id;
                    e.way_index = 2'(free_way);
                end
            end
        end
        pending_rsp.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        ctt_pkg::rsp_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected result status", out_ch.status, -1);
            else
            begin
                e = pending_rsp.pop_front();
                if (out_ch.status != e.status)
                    report_mismatch("status", out_ch.status, e.status);
                if (out_ch.owner_client != e.owner_client)
                    report_mismatch("owner_client", out_ch.owner_client, e.owner_client);
                if (out_ch.bucket_index != e.bucket_index)
                    report_mismatch("bucket_index", out_ch.bucket_index, e.bucket_index);
                if (out_ch.way_index != e.way_index)
                    report_mismatch("way_index", out_ch.way_index, e.way_index);
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ch.ready = 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready = 1'b1;
                if (rx_idle && $urandom_range(0, 3) == 0)
                    stall_left = gap_len();
            end
        end
    end

    // watchdog on transfers
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog == WDOG_MAX)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_item(input ctt_pkg::req_t r);
        int gap;
        in_ch.func        = r.func;
        in_ch.addr_first  = r.addr_first;
        in_ch.addr_second = r.addr_second;
        in_ch.port_first  = r.port_first;
        in_ch.port_second = r.port_second;
        in_ch.protocol    = r.protocol;
        in_ch.client_id   = r.client_id;
        in_ch.valid       = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_result(r);
        @(negedge clk);
        gap = tx_idle ? gap_len() : 0;
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic with_func(input ctt_pkg::req_t r, input logic [1:0] f, input bit swap);
        ctt_pkg::req_t s;
        s = r;
        s.func = f;
        if (swap)
        begin
            s.addr_first  = r.addr_second;
            s.addr_second = r.addr_first;
            s.port_first  = r.port_second;
            s.port_second = r.port_first;
        end
        send_item(s);
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_ttl(input logic [15:0] v);
        wait_drained();
        cfg_wdata = v;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        ttl_now = v;
    endtask

    task automatic tick(input int n);
        ctt_pkg::req_t t;
        t = '0;
        t.func = ctt_pkg::FUNC_TICK;
        repeat (n) send_item(t);
    endtask

    task automatic test_basic_ops();
        ctt_pkg::req_t a;
        ctt_pkg::req_t z;
        a = random_tuple(ctt_pkg::FUNC_CREATE);
        with_func(a, ctt_pkg::FUNC_LOOKUP, 1'b0);
        with_func(a, ctt_pkg::FUNC_CREATE, 1'b0);
        with_func(a, ctt_pkg::FUNC_LOOKUP, 1'b0);
        with_func(a, ctt_pkg::FUNC_LOOKUP, 1'b1);
        a.client_id = ~a.client_id;
        with_func(a, ctt_pkg::FUNC_CREATE, 1'b1);
        with_func(a, FUNC_UNUSED, 1'b0);
        z = '0;
        with_func(z, ctt_pkg::FUNC_CREATE, 1'b0);
        z = '1;
        with_func(z, ctt_pkg::FUNC_CREATE, 1'b0);
        with_func(z, ctt_pkg::FUNC_LOOKUP, 1'b0);
        tick(2);
    endtask

    task automatic test_bucket_full();
        ctt_pkg::req_t f [0:4];
        logic [9:0] b;
        b = $urandom;
        for (int k = 0; k < 5; k++)
        begin
            f[k] = tuple_in_bucket(b);
            with_func(f[k], ctt_pkg::FUNC_CREATE, 1'b0);
        end
        with_func(f[4], ctt_pkg::FUNC_LOOKUP, 1'b0);
        with_func(f[2], ctt_pkg::FUNC_LOOKUP, 1'b1);
    endtask

    task automatic test_expiry();
        ctt_pkg::req_t f [0:2];
        logic [9:0] b;
        write_ttl(16'd1);
        b = $urandom;
        for (int k = 0; k < 3; k++)
            f[k] = tuple_in_bucket(b);
        with_func(f[0], ctt_pkg::FUNC_CREATE, 1'b0);
        tick(1);
        with_func(f[0], ctt_pkg::FUNC_LOOKUP, 1'b0);
        with_func(f[1], ctt_pkg::FUNC_CREATE, 1'b0);
        write_ttl(16'd0);
        with_func(f[2], ctt_pkg::FUNC_CREATE, 1'b0);
        with_func(f[2], ctt_pkg::FUNC_LOOKUP, 1'b0);
        write_ttl(16'hFFFF);
        with_func(f[2], ctt_pkg::FUNC_CREATE, 1'b0);
        tick(3);
        with_func(f[2], ctt_pkg::FUNC_LOOKUP, 1'b1);
    endtask

    task automatic fill_pool();
        logic [9:0] b0;
        logic [9:0] b1;
        b0 = $urandom;
        b1 = b0 + 10'd1;
        for (int k = 0; k < 6; k++)
        begin
            flow_pool[k] = tuple_in_bucket(b0);
            flow_pool[6 + k] = tuple_in_bucket(b1);
        end
        for (int k = 12; k < 16; k++)
            flow_pool[k] = random_tuple(ctt_pkg::FUNC_CREATE);
    endtask

    task automatic test_random(input int n);
        ctt_pkg::req_t r;
        int   p;
        fill_pool();
        for (int k = 0; k < n; k++)
        begin
            p = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                r = random_tuple(ctt_pkg::FUNC_CREATE);
            else
            begin
                r = flow_pool[$urandom_range(0, 15)];
                r.client_id = $urandom;
            end
            if (p < 42)
                with_func(r, ctt_pkg::FUNC_LOOKUP, $urandom_range(0, 1));
            else if (p < 80)
                with_func(r, ctt_pkg::FUNC_CREATE, $urandom_range(0, 1));
            else if (p < 96)
                tick(1);
            else
                with_func(r, FUNC_UNUSED, 1'b0);
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_left = 400;
        tx_idle = 1'b0;
        test_random(40);
        tx_idle = 1'b1;
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.func = ctt_pkg::FUNC_LOOKUP;
        in_ch.addr_first = '0;
        in_ch.addr_second = '0;
        in_ch.port_first = '0;
        in_ch.port_second = '0;
        in_ch.protocol = '0;
        in_ch.client_id = '0;
        mismatches = 0;
        hold_left = 0;
        wdog = 0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        ttl_now = ctt_pkg::TTL_RESET;
        seconds_now = '0;
        for (int i = 0; i < NENTRIES; i++)
            tab_valid[i] = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_basic_ops();
        test_bucket_full();
        test_expiry();
        write_ttl(16'd3);
        test_random(300);
        test_backpressure();
        write_ttl(16'd60);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random(150);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        test_random(150);
        write_ttl(16'd1);
        test_random(250);
        write_ttl(16'hFFFF);
        test_random(200);
        write_ttl(16'd2);
        test_random(200);

        wait_drained();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
